// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define ASSERT_SYNC(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/acss_pkg.sv =====
// types, constants and helpers for the adc channel scan sequencer
package acss_pkg;

   // width of the enable mask register
   localparam int MASK_BITS = 15;
   // largest slot count the search logic covers
   localparam int MAX_SLOTS = 32;
   localparam int INDEX_BITS = 5;
   // converter channel code and reported slot widths
   localparam int CODE_BITS = 5;
   localparam int SLOT_OUT_BITS = 4;

   typedef logic [CODE_BITS-1:0] code_type;
   typedef logic [INDEX_BITS-1:0] index_type;
   typedef logic [MAX_SLOTS-1:0] slot_vec_type;

   typedef enum logic {
      PHASE_CHARGE,
      PHASE_CONVERT
   } phase_type;

   // converter input code of each slot, unused slots read as zero
   localparam code_type SLOT_CODE [MAX_SLOTS] = '{
      5'd5,  5'd4,  5'd2,  5'd15, 5'd14, 5'd13, 5'd12, 5'd23,
      5'd22, 5'd21, 5'd20, 5'd19, 5'd18, 5'd17, 5'd16, 5'd0,
      5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
      5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0
   };

   // index of the lowest set bit, zero when none is set
   function automatic index_type lowest_set(slot_vec_type vec);
      index_type idx;
      idx = '0;
      for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = index_type'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== hw/rtl/adc_channel_scan_sequencer_top.sv =====
// round-robin adc scan sequencer, one tick word in, one result word out
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  conversion_done, conversion_result
//   rsp      out        rsp_valid / rsp_stall  start, code, sample valid/slot/value, wrap
//   csr      in         csr_wr_en              csr_wr_data (enable mask)
//
// the next-enabled-slot search and the phase update sit between the input port
// and the result register, so a word can be taken every cycle while the result
// register drains.
// req_stall rises only while a result waits and rsp_stall holds it.
// synchronous reset empties the mask, returns to the charge phase on slot 0
// and empties the result register.
module adc_channel_scan_sequencer_top #(
   parameter int NUM_SLOTS = 15,
   parameter int SAMPLE_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   // tick channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_conversion_done,
   input  logic [SAMPLE_BITS-1:0]        req_conversion_result,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_start_conversion,
   output logic [acss_pkg::CODE_BITS-1:0] rsp_channel_code,
   output logic                          rsp_sample_valid,
   output logic [acss_pkg::SLOT_OUT_BITS-1:0] rsp_sample_slot,
   output logic [SAMPLE_BITS-1:0]        rsp_sample_value,
   output logic                          rsp_scan_wrapped,
   // mask register write
   input  logic                          csr_wr_en,
   input  logic [acss_pkg::MASK_BITS-1:0] csr_wr_data
);
   import acss_pkg::*;

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   // scan state
   logic [NUM_SLOTS-1:0] mask_ff;
   logic [NUM_SLOTS-1:0] mask_in;
   phase_type            phase_ff;
   phase_type            phase_in;
   logic [SLOT_W-1:0]    slot_ff;
   logic [SLOT_W-1:0]    slot_in;

   // result register
   logic                   rsp_valid_ff;
   logic                   start_ff;
   logic                   start_in;
   code_type               code_ff;
   code_type               code_in;
   logic                   sample_valid_ff;
   logic                   sample_valid_in;
   logic [SLOT_OUT_BITS-1:0] sample_slot_ff;
   logic [SLOT_OUT_BITS-1:0] sample_slot_in;
   logic [SAMPLE_BITS-1:0] sample_value_ff;
   logic [SAMPLE_BITS-1:0] sample_value_in;
   logic                   wrapped_ff;
   logic                   wrapped_in;

   logic         accept;
   logic         mask_empty;
   slot_vec_type live_wide;
   slot_vec_type above_cur;
   slot_vec_type csr_wide;
   index_type    cur_idx;
   index_type    next_idx;
   logic         no_higher;
   logic [NUM_SLOTS-1:0] csr_mask;

   // handshake: take a word unless a result is held back
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // mask bits above the slot count are dropped
   assign csr_wide = slot_vec_type'(csr_wr_data);
   assign csr_mask = csr_wide[NUM_SLOTS-1:0];

   // next enabled slot above the current one, else wrap to the lowest
   assign live_wide  = slot_vec_type'(mask_ff);
   assign mask_empty = (mask_ff == '0);
   assign cur_idx    = index_type'(slot_ff);

   always_comb begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
         above_cur[i] = live_wide[i] && (index_type'(i) > cur_idx);
      end
   end

   assign no_higher = (above_cur == '0);
   assign next_idx  = no_higher ? lowest_set(live_wide) : lowest_set(above_cur);

   // next scan state
   always_comb begin
      mask_in  = mask_ff;
      phase_in = phase_ff;
      slot_in  = slot_ff;
      priority if (csr_wr_en) begin
         mask_in  = csr_mask;
         phase_in = PHASE_CHARGE;
         slot_in  = SLOT_W'(lowest_set(slot_vec_type'(csr_mask)));
      end else if (accept && !mask_empty) begin
         unique case (phase_ff)
            PHASE_CHARGE: begin
               phase_in = PHASE_CONVERT;
            end
            PHASE_CONVERT: begin
               if (req_conversion_done) begin
                  phase_in = PHASE_CHARGE;
                  slot_in  = next_idx[SLOT_W-1:0];
               end
            end
            default: begin
               phase_in = PHASE_CHARGE;
            end
         endcase
      end
   end

   // result word for the tick being taken
   always_comb begin
      start_in        = 1'b0;
      code_in         = '0;
      sample_valid_in = 1'b0;
      sample_slot_in  = '0;
      sample_value_in = '0;
      wrapped_in      = 1'b0;
      if (!mask_empty) begin
         code_in = SLOT_CODE[cur_idx];
         unique case (phase_ff)
            PHASE_CHARGE: begin
               start_in = 1'b1;
            end
            PHASE_CONVERT: begin
               if (req_conversion_done) begin
                  code_in         = SLOT_CODE[next_idx];
                  sample_valid_in = 1'b1;
                  sample_slot_in  = SLOT_OUT_BITS'(cur_idx);
                  sample_value_in = req_conversion_result;
                  wrapped_in      = no_higher;
               end
            end
            default: begin
               start_in = 1'b0;
            end
         endcase
      end
   end

   // scan state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         phase_ff <= PHASE_CHARGE;
         slot_ff  <= '0;
      end else begin
         mask_ff  <= mask_in;
         phase_ff <= phase_in;
         slot_ff  <= slot_in;
      end
   end

   // result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload, loaded on each taken word
   always_ff @(posedge clock) begin
      if (accept) begin
         start_ff        <= start_in;
         code_ff         <= code_in;
         sample_valid_ff <= sample_valid_in;
         sample_slot_ff  <= sample_slot_in;
         sample_value_ff <= sample_value_in;
         wrapped_ff      <= wrapped_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_start_conversion = start_ff;
   assign rsp_channel_code     = code_ff;
   assign rsp_sample_valid     = sample_valid_ff;
   assign rsp_sample_slot      = sample_slot_ff;
   assign rsp_sample_value     = sample_value_ff;
   assign rsp_scan_wrapped     = wrapped_ff;

`include "assert_macros.svh"

   // the current slot is always one of the enabled slots
   `ASSERT_SYNC(a_slot_enabled, clock, reset, !mask_empty |-> mask_ff[slot_ff], "scan slot not enabled")
   // a tick with an empty mask gives an all-zero word
   `ASSERT_SYNC(a_empty_idle, clock, reset, (accept && mask_empty && !csr_wr_en) |=> (rsp_valid && !rsp_start_conversion && !rsp_sample_valid && (rsp_channel_code == '0)), "empty mask word not zero")
   // a charge tick starts a conversion and moves to the convert phase
   `ASSERT_SYNC(a_charge_step, clock, reset, (accept && !mask_empty && !csr_wr_en && (phase_ff == PHASE_CHARGE)) |=> (rsp_start_conversion && (phase_ff == PHASE_CONVERT)), "charge tick did not start")
   // a done tick stores a sample and returns to charge
   `ASSERT_SYNC(a_store_step, clock, reset, (accept && !mask_empty && !csr_wr_en && (phase_ff == PHASE_CONVERT) && req_conversion_done) |=> (rsp_sample_valid && !rsp_start_conversion && (phase_ff == PHASE_CHARGE)), "done tick did not store")

endmodule

// ===== tb/sv/adc_channel_scan_sequencer_top_tb.sv =====
// self-checking testbench for the adc channel scan sequencer top level
module adc_channel_scan_sequencer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import acss_pkg::*;

   localparam int SLOTS = 15;
   localparam int VALUE_BITS = 10;
   localparam int RANDOM_WORDS = 1200;
   localparam int STUCK_LIMIT = 2000;
   localparam int NUM_ROWS = 25;

   typedef logic [MASK_BITS-1:0] mask_type;
   typedef logic [VALUE_BITS-1:0] value_type;

   // one result word as the block reports it
   typedef struct packed {
      logic                     start;
      code_type                 code;
      logic                     valid;
      logic [SLOT_OUT_BITS-1:0] slot;
      value_type                value;
      logic                     wrapped;
   } scan_result_type;

   typedef enum logic {
      ROW_MASK,
      ROW_TICK
   } row_kind_type;

   // one line of the directed stimulus table
   typedef struct packed {
      row_kind_type    kind;
      mask_type        mask;
      logic            done;
      value_type       value;
      logic            typed;
      scan_result_type want;
   } stim_row_type;

   localparam scan_result_type ALL_ZERO = '0;

   // converter channel code of each slot
   localparam code_type CHANNEL_OF_SLOT [SLOTS] = '{
      5'd5,  5'd4,  5'd2,  5'd15, 5'd14, 5'd13, 5'd12, 5'd23,
      5'd22, 5'd21, 5'd20, 5'd19, 5'd18, 5'd17, 5'd16
   };

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_conversion_done;
   value_type req_conversion_result;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_start_conversion;
   code_type rsp_channel_code;
   logic rsp_sample_valid;
   logic [SLOT_OUT_BITS-1:0] rsp_sample_slot;
   value_type rsp_sample_value;
   logic rsp_scan_wrapped;
   logic csr_wr_en;
   mask_type csr_wr_data;

   // scan state tracked alongside the block
   mask_type scan_mask;
   phase_type scan_phase;
   logic [INDEX_BITS-1:0] scan_slot;
   value_type sample_mem [SLOTS];

   scan_result_type results_due [$];
   stim_row_type directed_rows [NUM_ROWS];
   logic tick_typed;
   scan_result_type tick_want;
   bit no_gaps;
   int fail_count;
   int stuck_cycles;

   adc_channel_scan_sequencer_top dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_conversion_done   (req_conversion_done),
      .req_conversion_result (req_conversion_result),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_start_conversion  (rsp_start_conversion),
      .rsp_channel_code      (rsp_channel_code),
      .rsp_sample_valid      (rsp_sample_valid),
      .rsp_sample_slot       (rsp_sample_slot),
      .rsp_sample_value      (rsp_sample_value),
      .rsp_scan_wrapped      (rsp_scan_wrapped),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // lowest enabled slot, slot 0 for an empty mask
   function automatic logic [INDEX_BITS-1:0] lowest_enabled(mask_type m);
      logic [INDEX_BITS-1:0] s;
      s = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (m[i]) s = INDEX_BITS'(i);
      end
      return s;
   endfunction

   // next enabled slot after cur, wrapping round
   function automatic logic [INDEX_BITS-1:0] following_enabled(mask_type m,
                                                               logic [INDEX_BITS-1:0] cur);
      int s;
      for (int i = 1; i <= SLOTS; i++) begin
         s = (int'(cur) + i) % SLOTS;
         if (m[s]) return INDEX_BITS'(s);
      end
      return cur;
   endfunction

   // one tick through the scan state, returns the result word it gives
   function automatic scan_result_type advance_scan(logic done, value_type value);
      scan_result_type res;
      logic [INDEX_BITS-1:0] nxt;
      res = '0;
      if (scan_mask == '0) return res;
      if (scan_phase == PHASE_CHARGE) begin
         res.start = 1'b1;
         res.code = CHANNEL_OF_SLOT[scan_slot];
         scan_phase = PHASE_CONVERT;
      end else if (done) begin
         nxt = following_enabled(scan_mask, scan_slot);
         sample_mem[scan_slot] = value;
         res.code = CHANNEL_OF_SLOT[nxt];
         res.valid = 1'b1;
         res.slot = scan_slot[SLOT_OUT_BITS-1:0];
         res.value = value;
         res.wrapped = (nxt == lowest_enabled(scan_mask));
         scan_slot = nxt;
         scan_phase = PHASE_CHARGE;
      end else begin
         res.code = CHANNEL_OF_SLOT[scan_slot];
      end
      return res;
   endfunction

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   // track register writes and accepted words, compare results in order
   always @(posedge clock) begin
      scan_result_type want;
      bit moved;
      moved = 1'b0;
      if (reset) begin
         scan_mask = '0;
         scan_phase = PHASE_CHARGE;
         scan_slot = '0;
         foreach (sample_mem[i]) sample_mem[i] = '0;
      end else begin
         if (csr_wr_en) begin
            scan_mask = csr_wr_data;
            scan_slot = lowest_enabled(scan_mask);
            scan_phase = PHASE_CHARGE;
            moved = 1'b1;
         end
         if (req_valid && !req_stall) begin
            want = advance_scan(req_conversion_done, req_conversion_result);
            results_due.push_back(tick_typed ? tick_want : want);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (results_due.size() == 0) begin
               $error("result word with nothing expected");
               fail_count++;
            end else begin
               want = results_due.pop_front();
               check_field("start_conversion", want.start, rsp_start_conversion);
               check_field("channel_code", want.code, rsp_channel_code);
               check_field("sample_valid", want.valid, rsp_sample_valid);
               check_field("sample_slot", want.slot, rsp_sample_slot);
               check_field("sample_value", want.value, rsp_sample_value);
               check_field("scan_wrapped", want.wrapped, rsp_scan_wrapped);
            end
         end
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_stall = !no_gaps && ($urandom_range(0, 99) < 18);
   end

   // watchdog on cycles with no progress
   initial begin
      while (stuck_cycles < STUCK_LIMIT) @(negedge clock);
      $display("FAIL");
      $finish;
   end

   // offer one tick word, with random gaps, and hold it until taken
   task automatic send_tick(logic done, value_type value, logic typed, scan_result_type want);
      @(negedge clock);
      while (!no_gaps && ($urandom_range(0, 99) < 18)) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_conversion_done = done;
      req_conversion_result = value;
      tick_typed = typed;
      tick_want = want;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // mask write once every outstanding result has come back
   task automatic write_mask(mask_type m);
      @(negedge clock);
      req_valid = 1'b0;
      while (results_due.size() != 0) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = m;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   initial begin
      int sent;
      int run_len;
      mask_type m;
      reset = 1'b1;
      req_valid = 1'b0;
      req_conversion_done = 1'b0;
      req_conversion_result = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      rsp_stall = 1'b0;
      tick_typed = 1'b0;
      tick_want = '0;
      no_gaps = 1'b0;
      fail_count = 0;
      stuck_cycles = 0;
      sent = 0;

      // directed table: kind, mask, done, value, typed, {start, code, valid, slot, value, wrap}
      directed_rows = '{
         // empty mask after reset gives an all-zero word
         '{ROW_TICK, 15'h0000, 1'b1, 10'h3FF, 1'b1, ALL_ZERO},
         '{ROW_MASK, 15'h7FFF, 1'b0, 10'h000, 1'b0, ALL_ZERO},
         '{ROW_TICK, 15'h0000, 1'b0, 10'h000, 1'b1, {1'b1, 5'd5, 1'b0, 4'd0, 10'h000, 1'b0}},
         // waiting for done keeps the current code
         '{ROW_TICK, 15'h0000, 1'b0, 10'h3FF, 1'b1, {1'b0, 5'd5, 1'b0, 4'd0, 10'h000, 1'b0}},
         '{ROW_TICK, 15'h0000, 1'b1, 10'h3FF, 1'b1, {1'b0, 5'd4, 1'b1, 4'd0, 10'h3FF, 1'b0}},
         // done during charge is ignored
         '{ROW_TICK, 15'h0000, 1'b1, 10'h000, 1'b1, {1'b1, 5'd4, 1'b0, 4'd0, 10'h000, 1'b0}},
         '{ROW_TICK, 15'h0000, 1'b1, 10'h000, 1'b1, {1'b0, 5'd2, 1'b1, 4'd1, 10'h000, 1'b0}},
         // single enabled slot wraps on every store
         '{ROW_MASK, 15'h4000, 1'b0, 10'h000, 1'b0, ALL_ZERO},
         '{ROW_TICK, 15'h0000, 1'b0, 10'h000, 1'b1, {1'b1, 5'd16, 1'b0, 4'd0, 10'h000, 1'b0}},
         '{ROW_TICK, 15'h0000, 1'b1, 10'h2AA, 1'b1, {1'b0, 5'd16, 1'b1, 4'd14, 10'h2AA, 1'b1}},
         '{ROW_TICK, 15'h0000, 1'b0, 10'h3FF, 1'b1, {1'b1, 5'd16, 1'b0, 4'd0, 10'h000, 1'b0}},
         '{ROW_TICK, 15'h0000, 1'b1, 10'h155, 1'b1, {1'b0, 5'd16, 1'b1, 4'd14, 10'h155, 1'b1}},
         // first and last slot only
         '{ROW_MASK, 15'h4001, 1'b0, 10'h000, 1'b0, ALL_ZERO},
         '{ROW_TICK, 15'h0000, 1'b0, 10'h000, 1'b0, ALL_ZERO},
         '{ROW_TICK, 15'h0000, 1'b1, 10'h3FF, 1'b0, ALL_ZERO},
         '{ROW_TICK, 15'h0000, 1'b0, 10'h000, 1'b0, ALL_ZERO},
         '{ROW_TICK, 15'h0000, 1'b1, 10'h001, 1'b0, ALL_ZERO},
         '{ROW_TICK, 15'h0000, 1'b0, 10'h000, 1'b0, ALL_ZERO},
         // mask rewritten while a conversion is pending
         '{ROW_MASK, 15'h0AAA, 1'b0, 10'h000, 1'b0, ALL_ZERO},
         '{ROW_TICK, 15'h0000, 1'b1, 10'h200, 1'b0, ALL_ZERO},
         '{ROW_TICK, 15'h0000, 1'b1, 10'h0FF, 1'b0, ALL_ZERO},
         // back to an empty mask
         '{ROW_MASK, 15'h0000, 1'b0, 10'h000, 1'b0, ALL_ZERO},
         '{ROW_TICK, 15'h0000, 1'b1, 10'h3FF, 1'b1, ALL_ZERO},
         '{ROW_MASK, 15'h5555, 1'b0, 10'h000, 1'b0, ALL_ZERO},
         '{ROW_TICK, 15'h0000, 1'b1, 10'h123, 1'b0, ALL_ZERO}
      };

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_MASK) begin
            write_mask(directed_rows[i].mask);
         end else begin
            send_tick(directed_rows[i].done, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].want);
         end
      end

      // random part: a mask per run, then a run of ticks
      while (sent < RANDOM_WORDS) begin
         case ($urandom_range(0, 9))
            0: m = '0;
            1: m = '1;
            2: m = mask_type'(1) << $urandom_range(0, SLOTS - 1);
            3: m = (mask_type'(1) << $urandom_range(0, SLOTS - 1)) |
                   (mask_type'(1) << $urandom_range(0, SLOTS - 1));
            default: m = mask_type'($urandom_range(1, 32767));
         endcase
         write_mask(m);
         run_len = (m == '0) ? $urandom_range(1, 4) : $urandom_range(4, 60);
         repeat (run_len) begin
            send_tick($urandom_range(0, 99) < 60, value_type'($urandom), 1'b0, ALL_ZERO);
            if (m != '0) sent++;
            // stretch with no gaps on either side
            no_gaps = (sent >= 500) && (sent < 700);
         end
      end
      no_gaps = 1'b0;

      @(negedge clock);
      req_valid = 1'b0;
      while (results_due.size() != 0) @(negedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
